### rtl/wmfa_pkg.sv
// Shared types, constants and the divider step for the matched-filter accumulator.
`default_nettype none
package wmfa_pkg;

   localparam int GATES      = 1024;
   localparam int GATE_W     = 10;
   localparam int INFO_W     = 47;
   localparam int DATA_W     = 48;
   localparam int QUOT_W     = 48;
   localparam int DIV_STAGES = QUOT_W / 2;
   localparam int QDEPTH     = 32;
   localparam int QAW        = $clog2(QDEPTH);
   localparam int RDEPTH     = 4;
   localparam int RAW        = $clog2(RDEPTH);

   localparam logic [1:0] CMD_ACC   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [INFO_W-1:0] INFO_MAX = {INFO_W{1'b1}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_ACC,
      KIND_READ,
      KIND_CLEAR,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [GATE_W-1:0]  gate;
      logic               used;
      logic signed [15:0] a_re;
      logic signed [15:0] a_im;
      logic signed [15:0] meas_re;
      logic signed [15:0] meas_im;
      logic [15:0]        noise_var;
   } req_type;

   typedef struct packed {
      logic [GATE_W-1:0]        out_gate;
      logic [INFO_W-1:0]        info_sum;
      logic signed [DATA_W-1:0] data_sum_re;
      logic signed [DATA_W-1:0] data_sum_im;
   } rsp_type;

   // One item handed from front to back
   typedef struct packed {
      kind_type                 kind;
      logic [GATE_W-1:0]        gate;
      logic [INFO_W-1:0]        info_q;
      logic signed [DATA_W-1:0] re_q;
      logic signed [DATA_W-1:0] im_q;
   } work_type;

   typedef struct packed {
      logic [INFO_W-1:0]        info;
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
   } acc_type;

   // Back part status seen by the top level
   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

   typedef struct packed {
      logic [15:0]       rem;
      logic [QUOT_W-1:0] dq;
   } div_type;

   // One restoring division step: shift a dividend bit into the remainder, shift a quotient bit in at the bottom
   function automatic div_type div_step(div_type d, logic [15:0] v);
      logic [16:0] r2;
      logic        qb;
      div_type     o;
      r2 = {d.rem, d.dq[QUOT_W-1]};
      qb = (r2 >= {1'b0, v});
      o.rem = qb ? 16'(r2 - {1'b0, v}) : r2[15:0];
      o.dq  = {d.dq[QUOT_W-2:0], qb};
      return o;
   endfunction

endpackage
`default_nettype wire

### rtl/wmfa_front.sv
// Front part: classify items, form products and divide them by the variance.
`default_nettype none
module wmfa_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire wmfa_pkg::req_type in_data,
   output logic                   out_valid,
   output wmfa_pkg::work_type     out_data
);
   import wmfa_pkg::*;

   typedef struct packed {
      kind_type          kind;
      logic [GATE_W-1:0] gate;
      logic [15:0]       divisor;
      logic              neg_re;
      logic              neg_im;
      div_type           d_info;
      div_type           d_re;
      div_type           d_im;
   } pipe_type;

   // product stage
   logic                 m_valid_ff;
   kind_type             m_kind_ff;
   logic [GATE_W-1:0]    m_gate_ff;
   logic [15:0]          m_var_ff;
   logic signed [31:0]   p_aa_ff, p_bb_ff, p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   kind_type             kind_in;

   // division stages
   logic                 d_valid_ff [DIV_STAGES+1];
   pipe_type             d_ff       [DIV_STAGES+1];
   pipe_type             d0_in;

   logic                 f_valid_ff;
   work_type             f_ff;
   work_type             f_in;

   logic [32:0]          pw;
   logic signed [32:0]   sre, sim;
   logic [31:0]          mre, mim;

   // classify the command
   always_comb begin
      unique case (in_data.cmd)
         CMD_ACC:   kind_in = in_data.used ? KIND_ACC : KIND_NOP;
         CMD_READ:  kind_in = KIND_READ;
         CMD_CLEAR: kind_in = KIND_CLEAR;
         default:   kind_in = KIND_NOP;
      endcase
   end

   // register the products
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= in_valid;
      end
      m_kind_ff <= kind_in;
      m_gate_ff <= in_data.gate;
      m_var_ff  <= (in_data.noise_var == 16'd0) ? 16'd1 : in_data.noise_var;
      p_aa_ff   <= in_data.a_re * in_data.a_re;
      p_bb_ff   <= in_data.a_im * in_data.a_im;
      p_rr_ff   <= in_data.a_re * in_data.meas_re;
      p_ii_ff   <= in_data.a_im * in_data.meas_im;
      p_ri_ff   <= in_data.a_re * in_data.meas_im;
      p_ir_ff   <= in_data.a_im * in_data.meas_re;
   end

   // sum the products and take magnitudes
   always_comb begin
      pw  = 33'(p_aa_ff) + 33'(p_bb_ff);
      sre = 33'(p_rr_ff) + 33'(p_ii_ff);
      sim = 33'(p_ri_ff) - 33'(p_ir_ff);
      mre = sre[32] ? 32'(-sre) : sre[31:0];
      mim = sim[32] ? 32'(-sim) : sim[31:0];
      d0_in.kind       = m_kind_ff;
      d0_in.gate       = m_gate_ff;
      d0_in.divisor    = m_var_ff;
      d0_in.neg_re     = sre[32];
      d0_in.neg_im     = sim[32];
      d0_in.d_info.rem = 16'd0;
      d0_in.d_info.dq  = {pw[31:0], 16'd0};
      d0_in.d_re.rem   = 16'd0;
      d0_in.d_re.dq    = {mre, 16'd0};
      d0_in.d_im.rem   = 16'd0;
      d0_in.d_im.dq    = {mim, 16'd0};
   end

   // advance the divider, two quotient bits a stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            d_valid_ff[k] <= 1'b0;
         end
      end else begin
         d_valid_ff[0] <= m_valid_ff;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            d_valid_ff[k] <= d_valid_ff[k-1];
         end
      end
      d_ff[0] <= d0_in;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         d_ff[k].kind    <= d_ff[k-1].kind;
         d_ff[k].gate    <= d_ff[k-1].gate;
         d_ff[k].divisor <= d_ff[k-1].divisor;
         d_ff[k].neg_re  <= d_ff[k-1].neg_re;
         d_ff[k].neg_im  <= d_ff[k-1].neg_im;
         d_ff[k].d_info  <= div_step(div_step(d_ff[k-1].d_info, d_ff[k-1].divisor),
                                     d_ff[k-1].divisor);
         d_ff[k].d_re    <= div_step(div_step(d_ff[k-1].d_re, d_ff[k-1].divisor),
                                     d_ff[k-1].divisor);
         d_ff[k].d_im    <= div_step(div_step(d_ff[k-1].d_im, d_ff[k-1].divisor),
                                     d_ff[k-1].divisor);
      end
   end

   // apply signs and clamp quotients to the sum ranges
   always_comb begin
      f_in.kind   = d_ff[DIV_STAGES].kind;
      f_in.gate   = d_ff[DIV_STAGES].gate;
      f_in.info_q = d_ff[DIV_STAGES].d_info.dq[QUOT_W-1] ?
                    INFO_MAX : d_ff[DIV_STAGES].d_info.dq[INFO_W-1:0];
      if (d_ff[DIV_STAGES].neg_re) begin
         f_in.re_q = DATA_W'(-d_ff[DIV_STAGES].d_re.dq);
      end else begin
         f_in.re_q = d_ff[DIV_STAGES].d_re.dq[QUOT_W-1] ?
                     DATA_MAX : d_ff[DIV_STAGES].d_re.dq;
      end
      if (d_ff[DIV_STAGES].neg_im) begin
         f_in.im_q = DATA_W'(-d_ff[DIV_STAGES].d_im.dq);
      end else begin
         f_in.im_q = d_ff[DIV_STAGES].d_im.dq[QUOT_W-1] ?
                     DATA_MAX : d_ff[DIV_STAGES].d_im.dq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= d_valid_ff[DIV_STAGES];
      end
      f_ff <= f_in;
   end

   assign out_valid = f_valid_ff;
   assign out_data  = f_ff;

endmodule
`default_nettype wire

### rtl/wmfa_queue.sv
// Short queue between the front and back parts.
`default_nettype none
module wmfa_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire wmfa_pkg::work_type push_data,
   input  wire logic               pop,
   output wmfa_pkg::work_type      head,
   output logic                    empty,
   output logic [wmfa_pkg::QAW:0]  count
);
   import wmfa_pkg::*;

   work_type       slot_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   count_ff;

   // hold entries and advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign head  = slot_ff[rd_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule
`default_nettype wire

### rtl/wmfa_back.sv
// Back part: gate accumulator memory, saturating update and result queue.
`default_nettype none
module wmfa_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire wmfa_pkg::work_type      q_head,
   input  wire logic                    q_empty,
   output wmfa_pkg::back_status_type    status,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output wmfa_pkg::rsp_type            rsp_data
);
   import wmfa_pkg::*;

   acc_type           mem [GATES];
   logic              clearing_ff;
   logic [GATE_W-1:0] clr_idx_ff;

   logic              pop;
   logic              b_valid_ff;
   work_type          b_ff;
   acc_type           rdata_ff;

   logic              fwd_valid_ff;
   logic [GATE_W-1:0] fwd_gate_ff;
   acc_type           fwd_ff;

   acc_type           cur, upd;
   logic              wr_en;
   logic [INFO_W:0]   s_info;
   logic [DATA_W:0]   s_re, s_im;

   rsp_type           rq_ff [RDEPTH];
   logic [RAW-1:0]    rq_wr_ff, rq_rd_ff;
   logic [RAW:0]      rq_count_ff;
   logic              rq_push, rq_pop;

   // take an item when the queue is not empty, the sweep is done and the result queue has room for it
   assign pop = !q_empty && !clearing_ff &&
                ((rq_count_ff + (RAW+1)'(b_valid_ff && b_ff.kind == KIND_READ))
                 < (RAW+1)'(RDEPTH));

   // forward the last write over the stale read
   always_comb begin
      cur = (fwd_valid_ff && fwd_gate_ff == b_ff.gate) ? fwd_ff : rdata_ff;
      s_info = {1'b0, cur.info} + {1'b0, b_ff.info_q};
      s_re   = {cur.re[DATA_W-1], cur.re} + {b_ff.re_q[DATA_W-1], b_ff.re_q};
      s_im   = {cur.im[DATA_W-1], cur.im} + {b_ff.im_q[DATA_W-1], b_ff.im_q};
      upd = '0;
      wr_en = 1'b0;
      case (b_ff.kind)
         KIND_ACC: begin
            wr_en = b_valid_ff;
            upd.info = s_info[INFO_W] ? INFO_MAX : s_info[INFO_W-1:0];
            if (s_re[DATA_W] != s_re[DATA_W-1]) begin
               upd.re = s_re[DATA_W] ? DATA_MIN : DATA_MAX;
            end else begin
               upd.re = s_re[DATA_W-1:0];
            end
            if (s_im[DATA_W] != s_im[DATA_W-1]) begin
               upd.im = s_im[DATA_W] ? DATA_MIN : DATA_MAX;
            end else begin
               upd.im = s_im[DATA_W-1:0];
            end
         end
         KIND_CLEAR: begin
            wr_en = b_valid_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // sweep the memory after reset, then read and write back
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == GATE_W'(GATES - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         b_valid_ff <= pop;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
      if (clearing_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[b_ff.gate] <= upd;
      end
      if (wr_en) begin
         fwd_gate_ff <= b_ff.gate;
         fwd_ff      <= upd;
      end
      rdata_ff <= mem[q_head.gate];
      b_ff     <= q_head;
   end

   // result queue
   assign rq_push = b_valid_ff && b_ff.kind == KIND_READ;
   assign rq_pop  = rsp_pop && rq_count_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         if (rq_push) begin
            rq_wr_ff <= rq_wr_ff + 1'b1;
         end
         if (rq_pop) begin
            rq_rd_ff <= rq_rd_ff + 1'b1;
         end
         rq_count_ff <= rq_count_ff + (RAW+1)'(rq_push) - (RAW+1)'(rq_pop);
      end
      if (rq_push) begin
         rq_ff[rq_wr_ff].out_gate    <= b_ff.gate;
         rq_ff[rq_wr_ff].info_sum    <= cur.info;
         rq_ff[rq_wr_ff].data_sum_re <= cur.re;
         rq_ff[rq_wr_ff].data_sum_im <= cur.im;
      end
   end

   assign rsp_empty       = (rq_count_ff == '0);
   assign rsp_data        = rq_ff[rq_rd_ff];
   assign status.clearing = clearing_ff;
   assign status.pop      = pop;

endmodule
`default_nettype wire

### rtl/whitened_matched_filter_accumulator.sv
// Per-gate diagonal precision and data accumulator with queue handshakes.
// From input transfer to result: the product stage, the 24-stage divider (two quotient
// bits per stage), the sign and clamp register, the queue and the update stage.
// Throughput: one item per cycle while results are taken.
// Reset: synchronous; afterwards a sweep zeroes all 1024 gates of the memory,
// during which req_full stays high.
`default_nettype none
module whitened_matched_filter_accumulator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire wmfa_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output wmfa_pkg::rsp_type      rsp_data
);
   import wmfa_pkg::*;

   logic            accept;
   logic            f_valid;
   work_type        f_data;
   work_type        q_head;
   logic            q_empty;
   logic [QAW:0]    q_count;
   back_status_type b_status;
   logic [QAW:0]    credit_ff;

   assign accept   = req_push && !req_full;
   assign req_full = b_status.clearing || credit_ff == (QAW+1)'(QDEPTH);

   // count items between input transfer and leaving the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_ff + (QAW+1)'(accept) - (QAW+1)'(b_status.pop);
      end
   end

   wmfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   wmfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_data),
      .pop       (b_status.pop),
      .head      (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   wmfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .status    (b_status),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (QAW+1)'(QDEPTH)) else $error("in-flight count overrun");

   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      q_count <= credit_ff) else $error("queue holds more than in flight");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      b_status.pop |-> !q_empty) else $error("pop from empty queue");

   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      b_status.clearing |-> req_full) else $error("transfer during sweep");

endmodule
`default_nettype wire

### test/tb_whitened_matched_filter_accumulator.sv
// Self-checking testbench for the per-gate precision and data accumulator.
module tb_whitened_matched_filter_accumulator;
   import wmfa_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   // Per-gate sums predicted from accepted transfers, and the reads still owed
   class gate_sum_board;
      logic [INFO_W-1:0]        info_mem [GATES];
      logic signed [DATA_W-1:0] re_mem [GATES];
      logic signed [DATA_W-1:0] im_mem [GATES];
      rsp_type                  owed_reads [$];
      int                       errors;
      int                       reads_seen;

      function new();
         for (int g = 0; g < GATES; g++) begin
            info_mem[g] = '0;
            re_mem[g] = '0;
            im_mem[g] = '0;
         end
         errors = 0;
         reads_seen = 0;
      endfunction

      // Divide (p << 16) by var, truncating toward zero, then clamp to the data range
      function automatic logic signed [63:0] data_quot(logic signed [63:0] p,
                                                        logic [63:0] v);
         logic [63:0]        mag;
         logic signed [63:0] q;
         mag = (p < 0) ? 64'(-p) : 64'(p);
         q = $signed((mag << 16) / v);
         if (p < 0) q = -q;
         return sat_data(q);
      endfunction

      function automatic logic signed [63:0] sat_data(logic signed [63:0] x);
         if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
         if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
         return x;
      endfunction

      // Note one accepted input transfer
      function void note_input(req_type r);
         logic signed [63:0] ar, ai, mr, mi;
         logic [63:0]        v, pw, qi;
         rsp_type            e;
         v = (r.noise_var == 0) ? 64'd1 : 64'(r.noise_var);
         ar = 64'(r.a_re); ai = 64'(r.a_im); mr = 64'(r.meas_re); mi = 64'(r.meas_im);
         if (r.cmd == CMD_ACC && r.used) begin
            pw = 64'(ar * ar + ai * ai);
            qi = (pw << 16) / v;
            if (qi > 64'(INFO_MAX)) qi = 64'(INFO_MAX);
            qi = qi + 64'(info_mem[r.gate]);
            info_mem[r.gate] = (qi > 64'(INFO_MAX)) ? INFO_MAX : qi[INFO_W-1:0];
            re_mem[r.gate] = DATA_W'(sat_data(64'(re_mem[r.gate])
                                              + data_quot(ar * mr + ai * mi, v)));
            im_mem[r.gate] = DATA_W'(sat_data(64'(im_mem[r.gate])
                                              + data_quot(ar * mi - ai * mr, v)));
         end else if (r.cmd == CMD_READ) begin
            e.out_gate = r.gate;
            e.info_sum = info_mem[r.gate];
            e.data_sum_re = re_mem[r.gate];
            e.data_sum_im = im_mem[r.gate];
            owed_reads.push_back(e);
         end else if (r.cmd == CMD_CLEAR) begin
            info_mem[r.gate] = '0;
            re_mem[r.gate] = '0;
            im_mem[r.gate] = '0;
         end
      endfunction

      // Check one result transfer against the oldest owed read
      function void check_result(rsp_type a);
         rsp_type e;
         reads_seen++;
         if (owed_reads.size() == 0) begin
            $display("%0t: unexpected result gate %0d", $time, a.out_gate);
            errors++;
            return;
         end
         e = owed_reads.pop_front();
         if (a.out_gate !== e.out_gate) begin
            $display("%0t: out_gate exp %0d got %0d", $time, e.out_gate, a.out_gate);
            errors++;
         end
         if (a.info_sum !== e.info_sum) begin
            $display("%0t: info_sum exp %0h got %0h", $time, e.info_sum, a.info_sum);
            errors++;
         end
         if (a.data_sum_re !== e.data_sum_re) begin
            $display("%0t: data_sum_re exp %0h got %0h", $time, e.data_sum_re,
                     a.data_sum_re);
            errors++;
         end
         if (a.data_sum_im !== e.data_sum_im) begin
            $display("%0t: data_sum_im exp %0h got %0h", $time, e.data_sum_im,
                     a.data_sum_im);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   gate_sum_board board = new();
   bit      calm_tail = 1'b0;
   bit      hold_off = 1'b0;
   int      sent = 0;

   whitened_matched_filter_accumulator uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) board.note_input(req_data);
         if (rsp_pop && !rsp_empty) board.check_result(rsp_data);
      end
   end

   // Drive pop at the falling edge: random stall bursts, plus one long hold-off
   initial begin : pop_driver
      int gap;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_pop <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_pop <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Hold the receiver off for a long stretch of cycles once traffic is flowing
   initial begin : hold_off_timer
      wait (sent >= 200);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (300) @(negedge clock);
      hold_off = 1'b0;
   end

   // Offer one item and hold it until the transfer
   task automatic send_item(req_type r);
      int gap;
      if (!calm_tail && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 11);
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   function automatic req_type make_item(logic [1:0] c, logic [9:0] g, logic u,
                                         logic [15:0] ar, logic [15:0] ai,
                                         logic [15:0] mr, logic [15:0] mi,
                                         logic [15:0] v);
      req_type r;
      r.cmd = c; r.gate = g; r.used = u;
      r.a_re = ar; r.a_im = ai; r.meas_re = mr; r.meas_im = mi; r.noise_var = v;
      return r;
   endfunction

   // Random item: mostly accumulates on a few hot gates, reads, clears and unknown commands mixed in
   function automatic req_type random_item();
      req_type     r;
      int          k;
      logic [15:0] pick [4];
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      k = $urandom_range(0, 99);
      r.cmd = (k < 70) ? CMD_ACC : (k < 88) ? CMD_READ : (k < 96) ? CMD_CLEAR
                                                                  : CMD_UNKNOWN;
      if ($urandom_range(0, 3) != 0) r.gate = 10'($urandom_range(0, 7));
      r.used = ($urandom_range(0, 4) != 0);
      pick[0] = 16'h8000; pick[1] = 16'h7FFF; pick[2] = 16'h0000; pick[3] = 16'hFFFF;
      if ($urandom_range(0, 5) == 0) r.a_re = pick[$urandom_range(0, 3)];
      if ($urandom_range(0, 5) == 0) r.a_im = pick[$urandom_range(0, 3)];
      if ($urandom_range(0, 5) == 0) r.meas_re = pick[$urandom_range(0, 3)];
      if ($urandom_range(0, 5) == 0) r.meas_im = pick[$urandom_range(0, 3)];
      case ($urandom_range(0, 5))
         0: r.noise_var = 16'($urandom_range(0, 3));
         1: r.noise_var = 16'hFFFF;
         default: ;
      endcase
      return r;
   endfunction

   initial begin : stimulus
      int cycles;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, every command, zero variance, unused, unknown command
      send_item(make_item(CMD_READ, 10'd5, 1'b0, 0, 0, 0, 0, 16'd1));
      send_item(make_item(CMD_ACC, 10'd5, 1'b1, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h8000, 16'd0));
      send_item(make_item(CMD_ACC, 10'd5, 1'b1, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h8000, 16'd1));
      send_item(make_item(CMD_READ, 10'd5, 1'b0, 0, 0, 0, 0, 16'd1));
      repeat (4)
         send_item(make_item(CMD_ACC, 10'd5, 1'b1, 16'h8000, 16'h8000, 16'h8000,
                             16'h8000, 16'd1));
      send_item(make_item(CMD_READ, 10'd5, 1'b0, 0, 0, 0, 0, 16'd1));
      send_item(make_item(CMD_ACC, 10'd1023, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'hFFFF));
      send_item(make_item(CMD_ACC, 10'd1023, 1'b1, 16'h7FFF, 16'h8000, 16'h8000,
                          16'h7FFF, 16'hFFFF));
      send_item(make_item(CMD_READ, 10'd1023, 1'b0, 0, 0, 0, 0, 16'd0));
      send_item(make_item(CMD_UNKNOWN, 10'd1023, 1'b1, 16'h7FFF, 0, 16'h7FFF, 0,
                          16'd1));
      send_item(make_item(CMD_READ, 10'd1023, 1'b0, 0, 0, 0, 0, 16'd0));
      send_item(make_item(CMD_CLEAR, 10'd5, 1'b0, 0, 0, 0, 0, 16'd0));
      send_item(make_item(CMD_READ, 10'd5, 1'b0, 0, 0, 0, 0, 16'd0));
      send_item(make_item(CMD_CLEAR, 10'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF));
      send_item(make_item(CMD_READ, 10'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF));

      // Random part; the receiver hold-off starts on its own timer
      for (int i = 0; i < 1350; i++) begin
         if (i == 1150) calm_tail = 1'b1;
         send_item(random_item());
      end
      req_push <= 1'b0;

      cycles = 0;
      while (board.owed_reads.size() != 0 && cycles < 100000) begin
         @(negedge clock);
         cycles++;
      end
      repeat (60) @(negedge clock);
      $display("Sent %0d items, checked %0d read results over accumulate, clear,",
               sent, board.reads_seen);
      $display("unknown-command, zero-variance, saturation and backpressure cases.");
      if (board.errors == 0 && board.owed_reads.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (board.owed_reads.size() != 0)
            $display("%0t: %0d reads never returned", $time, board.owed_reads.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule
